### rtl/core/twc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types and constants of the triangle wave channel: event codes,
// result word layout, length-counter load table and the ramp lookup.
// ----------------------------------------------------------------------------
package twc_pkg;

    // Event codes carried on the input tuser field
    typedef enum logic [2:0] {
        FUNC_LINEAR_WR  = 3'd0,
        FUNC_PERIOD_LO  = 3'd1,
        FUNC_PERIOD_HI  = 3'd2,
        FUNC_ENABLE_WR  = 3'd3,
        FUNC_TIMER_TICK = 3'd4,
        FUNC_QUARTER    = 3'd5,
        FUNC_HALF       = 3'd6
    } t_func;

    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned DATA_W    = 8;
    localparam int unsigned SAMPLE_W  = 4;
    localparam int unsigned PERIOD_W  = 11;
    localparam int unsigned LINEAR_W  = 7;
    localparam int unsigned LENGTH_W  = 8;
    localparam int unsigned STEP_W    = 5;

    // One result word
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                length_active;
    } t_result;

    // Length counter load values, indexed by period-high data bits 7..3
    localparam logic [LENGTH_W-1:0] LENGTH_TABLE [32] = '{
        8'd10,  8'd254, 8'd20,  8'd2,   8'd40,  8'd4,   8'd80,  8'd6,
        8'd160, 8'd8,   8'd60,  8'd10,  8'd14,  8'd12,  8'd26,  8'd14,
        8'd12,  8'd16,  8'd24,  8'd18,  8'd48,  8'd20,  8'd96,  8'd22,
        8'd192, 8'd24,  8'd72,  8'd26,  8'd16,  8'd28,  8'd32,  8'd30
    };

    // Ramp level: 15 down to 0 over the first half, 0 up to 15 over the second
    function automatic logic [SAMPLE_W-1:0] ramp_level(input logic [STEP_W-1:0] step);
        ramp_level = step[STEP_W-1] ? step[SAMPLE_W-1:0] : ~step[SAMPLE_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/core/twc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_core
// Channel state and per-event update; produces the result word that follows
// from the state after the event.
// ----------------------------------------------------------------------------
module twc_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_step,
    input  wire twc_pkg::t_func           i_func,
    input  wire logic [twc_pkg::DATA_W-1:0] i_data,
    output twc_pkg::t_result              o_result
);
    import twc_pkg::*;

    logic                r_enabled,      n_enabled;
    logic                r_halt,         n_halt;
    logic [LINEAR_W-1:0] r_lin_reload,   n_lin_reload;
    logic [LINEAR_W-1:0] r_lin_count,    n_lin_count;
    logic                r_lin_pending,  n_lin_pending;
    logic [LENGTH_W-1:0] r_len_count,    n_len_count;
    logic [PERIOD_W-1:0] r_period,       n_period;
    logic [PERIOD_W-1:0] r_countdown,    n_countdown;
    logic [STEP_W-1:0]   r_step_pos,     n_step_pos;

    always_comb begin
        n_enabled     = r_enabled;
        n_halt        = r_halt;
        n_lin_reload  = r_lin_reload;
        n_lin_count   = r_lin_count;
        n_lin_pending = r_lin_pending;
        n_len_count   = r_len_count;
        n_period      = r_period;
        n_countdown   = r_countdown;
        n_step_pos    = r_step_pos;
        case (i_func)
            FUNC_LINEAR_WR: begin
                n_halt       = i_data[7];
                n_lin_reload = i_data[LINEAR_W-1:0];
            end
            FUNC_PERIOD_LO: begin
                n_period = {r_period[PERIOD_W-1:8], i_data};
            end
            FUNC_PERIOD_HI: begin
                n_period = {i_data[2:0], r_period[7:0]};
                if (r_enabled) begin
                    n_len_count = LENGTH_TABLE[i_data[7:3]];
                end
                n_lin_pending = 1'b1;
            end
            FUNC_ENABLE_WR: begin
                n_enabled = i_data[0];
                if (!i_data[0]) begin
                    n_len_count = '0;
                end
            end
            FUNC_TIMER_TICK: begin
                // Reload on zero and advance the ramp while both counters run
                if (r_countdown == '0) begin
                    n_countdown = r_period;
                    if ((r_len_count != '0) && (r_lin_count != '0)) begin
                        n_step_pos = r_step_pos + STEP_W'(1);
                    end
                end else begin
                    n_countdown = r_countdown - PERIOD_W'(1);
                end
            end
            FUNC_QUARTER: begin
                if (r_lin_pending) begin
                    n_lin_count = r_lin_reload;
                end else if (r_lin_count != '0) begin
                    n_lin_count = r_lin_count - LINEAR_W'(1);
                end
                if (!r_halt) begin
                    n_lin_pending = 1'b0;
                end
            end
            FUNC_HALF: begin
                if (!r_halt && (r_len_count != '0)) begin
                    n_len_count = r_len_count - LENGTH_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b0;
            r_halt        <= 1'b0;
            r_lin_reload  <= '0;
            r_lin_count   <= '0;
            r_lin_pending <= 1'b0;
            r_len_count   <= '0;
            r_period      <= '0;
            r_countdown   <= '0;
            r_step_pos    <= '0;
        end else if (i_step) begin
            r_enabled     <= n_enabled;
            r_halt        <= n_halt;
            r_lin_reload  <= n_lin_reload;
            r_lin_count   <= n_lin_count;
            r_lin_pending <= n_lin_pending;
            r_len_count   <= n_len_count;
            r_period      <= n_period;
            r_countdown   <= n_countdown;
            r_step_pos    <= n_step_pos;
        end
    end

    // Silence when disabled, either counter is empty, or the period is ultrasonic
    always_comb begin
        o_result.length_active = (n_len_count != '0);
        if (n_enabled && (n_len_count != '0) && (n_lin_count != '0)
            && (n_period[PERIOD_W-1:1] != '0)) begin
            o_result.sample = ramp_level(n_step_pos);
        end else begin
            o_result.sample = '0;
        end
    end

endmodule
`default_nettype wire

### rtl/core/triangle_wave_channel_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_wave_channel_unit
// Triangle wave sound channel driven by a stream of events.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one event per word. tuser carries the event code
//   (linear write, period low, period high/length, enable, timer tick,
//   quarter frame, half frame); tdata carries the byte for register writes
//   or the enable bit. Code 7 changes nothing and still yields a word.
//   Output stream (m_axis): exactly one word per event, in order. tdata[3:0]
//   is the sample level after the event, tuser[0] flags a running length
//   counter.
//   Path: the event sits in the input register; once the output slot is
//   free, the state update and its result word land in the output register
//   together, and the receiver takes the word from there.
//   Throughput: one event per cycle; s_axis_tready stays high whenever the
//   output register is empty or being drained.
//   Stall: when m_axis_tready is low the output word holds, one more event
//   parks in the input register, and then s_axis_tready drops until the
//   receiver takes the word.
//   Reset (i_rst_n low, synchronous): all channel state clears to zero and
//   both stream stages empty.
// ----------------------------------------------------------------------------
module triangle_wave_channel_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] data
    input  wire logic [2:0] s_axis_tuser,   // [2:0] func
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [3:0] sample, [7:4] zero
    output logic [0:0]      m_axis_tuser    // [0] length_active
);
    import twc_pkg::*;

    logic              r_in_valid;
    t_func             r_in_func;
    logic [DATA_W-1:0] r_in_data;
    logic              r_out_valid;
    t_result           r_out;
    t_result           core_result;
    logic              advance;

    // Move the parked event into the core when the output slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_func <= t_func'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
    end

    twc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_func   (r_in_func),
        .i_data   (r_in_data),
        .o_result (core_result)
    );

    // Output register: load on advance, drop once the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(8 - SAMPLE_W){1'b0}}, r_out.sample};
    assign m_axis_tuser  = r_out.length_active;

endmodule
`default_nettype wire
